/* design/c2s_pkg.sv */
// Shared constants and the arctangent table for the Cartesian to spherical converter.
// No dependencies.
package c2s_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;
  localparam int ROOT_W           = 24;          // root width of both square roots
  localparam int SQ_W             = 2 * ROOT_W;  // radicand width
  localparam int CW               = 27;          // cordic x/y datapath width
  localparam int ACC_W            = 32;          // angle accumulator, pi = 2^31

  // atan(2^-i) in units where pi = 2^31, rounded
  function automatic logic [ACC_W-1:0] atan_entry(input int unsigned idx);
    logic [ACC_W-1:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/c2s_isqrt.sv */
// Pipelined integer square root, one root bit per stage (restoring method).
// Depends on nothing but its parameter; the enclosing pipeline supplies the stall enable.
module c2s_isqrt #(
  parameter int RootW = 24
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [2*RootW-1:0]   n_i,
  output logic [RootW-1:0]     root_o,
  output logic [2*RootW-1:0]   rem_o
);

  localparam int N = 2 * RootW;

  logic [N-1:0]     rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];

  for (genvar i = 0; i < RootW; i++) begin : g_step
    localparam int B = RootW - 1 - i;
    logic [N-1:0]     rem_in;
    logic [RootW-1:0] root_in;
    logic [N-1:0]     trial;

    if (i == 0) begin : g_first
      assign rem_in  = n_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = (N'(root_in) << (B + 1)) + (N'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[i]  <= rem_in - trial;
          root_q[i] <= root_in | (RootW'(1) << B);
        end else begin
          rem_q[i]  <= rem_in;
          root_q[i] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[RootW-1];
  assign rem_o  = rem_q[RootW-1];

endmodule

/* design/c2s_cordic.sv */
// Pipelined vectoring cordic, one micro-rotation per stage, angle of (a, b) with a >= 0.
// Depends on c2s_pkg for the datapath widths and the arctangent table.
module c2s_cordic #(
  parameter int Steps = c2s_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [c2s_pkg::CW-1:0]     a_i,
  input  logic signed [c2s_pkg::CW-1:0]     b_i,
  output logic signed [c2s_pkg::ACC_W-1:0]  acc_o
);

  localparam int W = c2s_pkg::CW;
  localparam int A = c2s_pkg::ACC_W;

  logic signed [W-1:0] x_q   [Steps];
  logic signed [W-1:0] y_q   [Steps];
  logic signed [A-1:0] acc_q [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_rot
    localparam logic signed [A-1:0] Ang = c2s_pkg::atan_entry(i);
    logic signed [W-1:0] x_in, y_in, xs, ys;
    logic signed [A-1:0] acc_in;

    if (i == 0) begin : g_first
      assign x_in   = a_i;
      assign y_in   = b_i;
      assign acc_in = '0;
    end else begin : g_next
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign acc_in = acc_q[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;

    // rotate toward the x axis
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[W-1]) begin
          x_q[i]   <= x_in + ys;
          y_q[i]   <= y_in - xs;
          acc_q[i] <= acc_in + Ang;
        end else begin
          x_q[i]   <= x_in - ys;
          y_q[i]   <= y_in + xs;
          acc_q[i] <= acc_in - Ang;
        end
      end
    end
  end

  assign acc_o = acc_q[Steps-1];

endmodule

/* design/cartesian_to_spherical.sv */
// Cartesian to spherical converter top level: squares, two square roots, two cordics.
// Depends on c2s_pkg, c2s_isqrt and c2s_cordic.
//
// One point is taken every cycle while the output is not stalled. The pipeline has 28 + CORDIC_STEPS register stages
// (3 setup stages, 24 square-root stages, one stage per cordic step, one output stage).
// The length is set by the bit-per-stage square root of x^2 + y^2 feeding the polar
// cordic. The whole pipeline holds while a finished result is not taken.
module cartesian_to_spherical #(
  parameter int CORDIC_STEPS = c2s_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic signed [15:0] coord_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        radius_o,
  output logic [15:0]        polar_angle_o,
  output logic signed [15:0] azimuth_o,
  output logic               on_axis_o
);

  localparam int RW  = c2s_pkg::ROOT_W;
  localparam int NW  = c2s_pkg::SQ_W;
  localparam int CW  = c2s_pkg::CW;
  localparam int AW  = c2s_pkg::ACC_W;
  localparam int LAT = 3 + RW + CORDIC_STEPS + 1;

  typedef struct packed {
    logic [15:0]        ax;
    logic signed [15:0] y;
    logic [15:0]        az;
    logic               zneg;
    logic               axis;
  } side_t;

  typedef struct packed {
    logic [15:0] r;
    logic        zneg;
    logic        axis;
  } post_t;

  logic en;
  logic [LAT-1:0] vld_q;

  // the whole pipeline moves unless the output beat is stalled
  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // input, squares and sums
  logic signed [15:0] xa_q, ya_q, za_q;
  logic signed [15:0] xb_q, yb_q, zb_q;
  logic [31:0]        xx_q, yy_q, zz_q;
  logic [31:0]        s2_q, s3_q;
  side_t              sc_q;
  logic signed [31:0] xx_d, yy_d, zz_d;

  assign xx_d = xa_q * xa_q;
  assign yy_d = ya_q * ya_q;
  assign zz_d = za_q * za_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q <= coord_x_i;
      ya_q <= coord_y_i;
      za_q <= coord_z_i;
      xx_q <= 32'(xx_d);
      yy_q <= 32'(yy_d);
      zz_q <= 32'(zz_d);
      xb_q <= xa_q;
      yb_q <= ya_q;
      zb_q <= za_q;
      s2_q <= xx_q + yy_q;
      s3_q <= xx_q + yy_q + zz_q;
      sc_q.ax   <= xb_q[15] ? 16'(-xb_q) : 16'(xb_q);
      sc_q.y    <= yb_q;
      sc_q.az   <= zb_q[15] ? 16'(-zb_q) : 16'(zb_q);
      sc_q.zneg <= zb_q[15];
      sc_q.axis <= (xb_q == '0) && (yb_q == '0);
    end
  end

  // square roots of x^2+y^2 (scaled by 2^16) and x^2+y^2+z^2
  logic [RW-1:0] rho, root_r;
  logic [NW-1:0] rem_rho, rem_r;

  c2s_isqrt #(.RootW(RW)) u_sqrt_rho (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    ({s2_q, 16'b0}),
    .root_o (rho),
    .rem_o  (rem_rho)
  );

  c2s_isqrt #(.RootW(RW)) u_sqrt_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    ({16'b0, s3_q}),
    .root_o (root_r),
    .rem_o  (rem_r)
  );

  side_t side_q [RW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= sc_q;
      for (int i = 1; i < RW; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // round the radius half up: bump when remainder exceeds root
  logic [15:0] r_round;
  assign r_round = 16'(root_r) + 16'(rem_r > NW'(root_r));

  // angle cordics
  logic signed [CW-1:0] th_a, th_b, ph_a, ph_b;
  logic signed [AW-1:0] acc_th, acc_ph;
  side_t                sd;

  assign sd   = side_q[RW-1];
  assign th_a = CW'({sd.ax, 8'b0});
  assign th_b = CW'(sd.y) <<< 8;
  assign ph_a = CW'({sd.az, 8'b0});
  assign ph_b = CW'(rho);

  c2s_cordic #(.Steps(CORDIC_STEPS)) u_cordic_th (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (th_a),
    .b_i   (th_b),
    .acc_o (acc_th)
  );

  c2s_cordic #(.Steps(CORDIC_STEPS)) u_cordic_ph (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ph_a),
    .b_i   (ph_b),
    .acc_o (acc_ph)
  );

  post_t post_q [CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      post_q[0] <= '{r: r_round, zneg: sd.zneg, axis: sd.axis};
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        post_q[i] <= post_q[i-1];
      end
    end
  end

  // scale to output units, fold the lower half space, clamp
  post_t              pf;
  logic signed [AW:0] th_sum;
  logic signed [16:0] th_u;
  logic signed [AW+1:0] ph_acc, ph_sum;
  logic signed [17:0] ph_u;
  logic signed [15:0] azimuth_d;
  logic [15:0]        polar_d;

  assign pf     = post_q[CORDIC_STEPS-1];
  assign th_sum = (AW+1)'(acc_th) + (AW+1)'(33'sd32768);
  assign th_u   = 17'(th_sum >>> 16);
  assign ph_acc = pf.zneg ? ((AW+2)'(34'sh80000000) - (AW+2)'(acc_ph)) : (AW+2)'(acc_ph);
  assign ph_sum = ph_acc + (AW+2)'(34'sd32768);
  assign ph_u   = 18'(ph_sum >>> 16);

  always_comb begin
    if (pf.axis) begin
      azimuth_d = '0;
      polar_d   = pf.zneg ? 16'd32768 : 16'd0;
    end else begin
      if (th_u > 17'sd16384) begin
        azimuth_d = 16'sd16384;
      end else if (th_u < -17'sd16384) begin
        azimuth_d = -16'sd16384;
      end else begin
        azimuth_d = 16'(th_u);
      end
      if (ph_u < 18'sd0) begin
        polar_d = '0;
      end else if (ph_u > 18'sd32768) begin
        polar_d = 16'd32768;
      end else begin
        polar_d = 16'(ph_u);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      radius_o      <= pf.r;
      polar_angle_o <= polar_d;
      azimuth_o     <= azimuth_d;
      on_axis_o     <= pf.axis;
    end
  end

endmodule
